// File: hdl/sha512_hash_engine_macros.svh
// Assertion macros for the SHA-512 engine controller.
// No dependencies.
`ifndef SHA512_HASH_ENGINE_MACROS_SVH
`define SHA512_HASH_ENGINE_MACROS_SVH

// Implication check clocked on clk_i, quiet while reset is low.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sha512_pkg.sv
// Shared types, round constants and functions for the SHA-512 engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned Rounds = 80;

  typedef logic [WordW-1:0] word_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic       load_byte;   // shift one byte into the block window
    logic [7:0] byte_val;
    logic       start;       // load working vars from chaining value
    logic       round;       // perform one round
    logic [6:0] round_idx;
    logic       add_back;    // fold working vars into chaining value
    logic       reinit;      // restore initial hash values
    logic       shift_out;   // rotate chaining words towards H0
  } sha_cmd_t;

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    k = '0;
    case (t)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    h = '0;
    case (i)
      3'd0: h = 64'h6a09e667f3bcc908; 3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b; 3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1; 3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b; 3'd7: h = 64'h5be0cd19137e2179;
      default: h = '0;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

// File: hdl/sha512_ctrl.sv
// Controller for the SHA-512 engine: byte intake, padding, round count, output.
// Depends on sha512_pkg and sha512_hash_engine_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
module sha512_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               in_action_i,
  input  wire logic [7:0]         in_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              out_index_o,
  output sha512_pkg::sha_cmd_t    cmd_o
);
  import sha512_pkg::*;
  `include "sha512_hash_engine_macros.svh"

  typedef enum logic [2:0] {
    StIdle, StPad, StLen, StRound, StAdd, StOut
  } state_e;

  state_e     state_q, state_d;
  logic [63:0] count_q, count_d;
  logic [63:0] bits_q, bits_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        fin_q, fin_d;     // compression belongs to a finish
  logic        lenph_q, lenph_d; // padding has reached the length field
  logic [3:0]  lcnt_q, lcnt_d;   // length bytes written
  logic        load;
  logic [7:0]  bval;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_index_o = oidx_q;

  always_comb begin
    state_d = state_q; count_d = count_q; bits_d = bits_q; rnd_d = rnd_q;
    oidx_d = oidx_q; fin_d = fin_q; lenph_d = lenph_q; lcnt_d = lcnt_q;
    load = 1'b0; bval = 8'h00;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          load = 1'b1;
          if (in_action_i) begin
            bval = 8'h80; fin_d = 1'b1; bits_d = {count_q[60:0], 3'b000};
            lenph_d = 1'b0; lcnt_d = '0;
          end else begin
            bval = in_byte_i; fin_d = 1'b0;
          end
        end
      end
      StPad: begin
        load = 1'b1;
        if (lenph_q) begin
          lcnt_d = lcnt_q + 4'd1;
          bval = (lcnt_q[3]) ? bits_q[63 - 8*lcnt_q[2:0] -: 8] : 8'h00;
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(Rounds - 1)) state_d = StAdd;
      end
      StAdd: begin
        cmd_o.add_back = 1'b1;
        rnd_d = '0;
        // The length field closes the last block; without it another block follows.
        if (!fin_q) state_d = StIdle;
        else if (!lenph_q) state_d = StPad;
        else begin state_d = StOut; oidx_d = '0; end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.shift_out = 1'b1;
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d = StIdle; cmd_o.reinit = 1'b1; count_d = '0; fin_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (load) begin
      cmd_o.load_byte = 1'b1;
      cmd_o.byte_val = bval;
      count_d = count_q + 64'd1;
      if (fin_d && count_d[6:0] == 7'd112) lenph_d = 1'b1;
      if (count_d[6:0] == 7'd0) begin
        state_d = StRound; cmd_o.start = 1'b1; rnd_d = '0;
      end else if (fin_d) state_d = StPad;
      else state_d = StIdle;
    end
    cmd_o.round_idx = rnd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; bits_q <= '0; rnd_q <= '0;
      oidx_q <= '0; fin_q <= 1'b0; lenph_q <= 1'b0; lcnt_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; bits_q <= bits_d; rnd_q <= rnd_d;
      oidx_q <= oidx_d; fin_q <= fin_d; lenph_q <= lenph_d; lcnt_q <= lcnt_d;
    end
  end

  `SHA_ASSERT_IMP(a_rnd_range, state_q == StRound, rnd_q < 7'(Rounds), "round out of range")
  `SHA_ASSERT_NXT(a_out_done, state_q == StOut && out_ready_i && oidx_q == 3'd7,
    state_q == StIdle && count_q == 64'd0, "no restart after digest")
  `SHA_ASSERT_IMP(a_len_only_fin, lenph_q && state_q == StPad, fin_q, "length outside finish")
endmodule
`default_nettype wire

// File: hdl/sha512_dp.sv
// Datapath for the SHA-512 engine: block window, schedule, rounds, chaining words.
// Depends on sha512_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha512_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sha512_pkg::sha_cmd_t cmd_i,
  output sha512_pkg::word_t      digest_o
);
  import sha512_pkg::*;

  word_t blk_q [16];   // block bytes, then rolling schedule
  word_t v_q [8];
  word_t h_q [8];
  word_t a, b, wt, s0, s1, t1, t2, ch, mj, wn;

  always_comb begin
    a  = blk_q[1];
    b  = blk_q[14];
    wn = blk_q[0] + (ror(a, 1) ^ ror(a, 8) ^ (a >> 7)) + blk_q[9]
       + (ror(b, 19) ^ ror(b, 61) ^ (b >> 6));
    wt = (cmd_i.round_idx < 7'd16) ? blk_q[0] : wn;
    s1 = ror(v_q[4], 14) ^ ror(v_q[4], 18) ^ ror(v_q[4], 41);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + round_k(cmd_i.round_idx) + wt;
    s0 = ror(v_q[0], 28) ^ ror(v_q[0], 34) ^ ror(v_q[0], 39);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = s0 + mj;
  end

  assign digest_o = h_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      for (int i = 0; i < 15; i++) blk_q[i] <= {blk_q[i][55:0], blk_q[i+1][63:56]};
      blk_q[15] <= {blk_q[15][55:0], cmd_i.byte_val};
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
      blk_q[15] <= wt;
    end
    // start happens with the last byte load; the window finishes filling that cycle
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else if (cmd_i.reinit) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else if (cmd_i.add_back) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end else if (cmd_i.shift_out) begin
      for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
      h_q[7] <= h_q[0];
    end
  end
endmodule
`default_nettype wire

// File: hdl/sha512_hash_engine.sv
// Top level of the SHA-512 engine: stream ports, controller and datapath.
// Depends on sha512_pkg, sha512_ctrl and sha512_dp.
// Append: one byte a cycle; a full 128-byte block holds tready low while it is compressed.
// Finish (c = length mod 128): padding and length are loaded and the last block compressed
// (extra block if c >= 112), then word 0 is valid; eight words follow, one per ready cycle.
// Reset (rst_ni low, asynchronous): initial hash words, byte count zero, engine idle.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // [63:0] digest_word, [66:64] word_index
  output logic             m_axis_tlast   // last_word
);
  import sha512_pkg::*;
  sha_cmd_t cmd;
  word_t    dig;
  logic [2:0] idx;

  sha512_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_action_i(s_axis_tuser), .in_byte_i(s_axis_tdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_index_o(idx), .cmd_o(cmd)
  );

  sha512_dp u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .digest_o(dig));

  assign m_axis_tdata = {5'd0, idx, dig};
  assign m_axis_tlast = (idx == 3'd7);
endmodule
`default_nettype wire
